### hdl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error("assert");
`else
`define ASSERT_IMPL(label, clk, rstn, prop)
`define ASSERT_ALWAYS(label, clk, rstn, expr)
`endif
`endif

### hdl/nhst_pkg.sv
`timescale 1ns / 1ps
package nhst_pkg;
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int COUNT_W = 7;

    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_REGISTER = 2'd1;
    localparam logic [1:0] REQ_UNREGISTER = 2'd2;
    localparam logic [1:0] REQ_RSVD = 2'd3;

    localparam logic [3:0] OC_SKIPPED = 4'd0;
    localparam logic [3:0] OC_UNCHANGED = 4'd1;
    localparam logic [3:0] OC_UPDATED = 4'd2;
    localparam logic [3:0] OC_PUSHED = 4'd3;
    localparam logic [3:0] OC_INSERTED = 4'd4;
    localparam logic [3:0] OC_FOUND = 4'd5;
    localparam logic [3:0] OC_CREATED = 4'd6;
    localparam logic [3:0] OC_REMOVED = 4'd7;
    localparam logic [3:0] OC_KEPT = 4'd8;
    localparam logic [3:0] OC_NOT_FOUND = 4'd9;
    localparam logic [3:0] OC_FULL = 4'd10;

    localparam logic [1:0] CONN_UNSET = 2'd0;
    localparam logic [1:0] CONN_NO = 2'd1;
    localparam logic [1:0] CONN_YES = 2'd2;
    localparam logic [1:0] CONN_RSVD = 2'd3;
    localparam logic [1:0] RC_NONE = 2'd0;
    localparam logic [1:0] RC_UP = 2'd1;
    localparam logic [1:0] RC_DOWN = 2'd2;

    // normalized request passed from front to back
    typedef struct packed {
        logic [1:0]  req;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        v6;
        logic        reach;
        logic        cv;
        logic [31:0] cost;
        logic [1:0]  conn;
    } req_t;

    // stored entry: valid mark, key plus status
    typedef struct packed {
        logic        valid;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        v6;
        logic        reach;
        logic        cv;
        logic [31:0] cost;
        logic [1:0]  conn;
        logic        regd;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [3:0]  outcome;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        v6;
        logic        reach;
        logic        cv;
        logic [31:0] cost;
        logic [1:0]  conn;
        logic        push;
        logic [1:0]  rchg;
        logic [6:0]  count;
    } res_t;
endpackage

### hdl/nhst_ram.sv
`timescale 1ns / 1ps
module nhst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

### hdl/nhst_front.sv
`timescale 1ns / 1ps
module nhst_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_req_type,
    input  logic [63:0]         s_addr_hi,
    input  logic [63:0]         s_addr_lo,
    input  logic                s_addr_is_v6,
    input  logic                s_reachable,
    input  logic                s_cost_valid,
    input  logic [31:0]         s_igp_cost,
    input  logic [1:0]          s_connected_state,
    output logic                q_valid,
    input  logic                q_ready,
    output nhst_pkg::req_t      q_data
);
    // two-entry queue of normalized requests
    nhst_pkg::req_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    nhst_pkg::req_t norm;

    always_comb begin
        norm.req   = s_req_type;
        norm.v6    = s_addr_is_v6;
        norm.hi    = s_addr_is_v6 ? s_addr_hi : 64'd0;
        norm.lo    = s_addr_is_v6 ? s_addr_lo : {32'd0, s_addr_lo[31:0]};
        norm.reach = s_reachable;
        norm.cv    = s_cost_valid;
        norm.cost  = s_cost_valid ? s_igp_cost : 32'd0;
        norm.conn  = (s_connected_state == nhst_pkg::CONN_RSVD) ? nhst_pkg::CONN_UNSET
                                                                : s_connected_state;
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = q_reg[0];

    logic push, pop;
    assign push = s_valid && s_ready;
    assign pop  = q_valid && q_ready;
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) cnt_reg <= 2'd0;
        else cnt_reg <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (push && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop))) q_reg[0] <= norm;
        else if (pop) q_reg[0] <= q_reg[1];
        if (push && cnt_reg == 2'd1 && !pop) q_reg[1] <= norm;
    end
endmodule

### hdl/nhst_back.sv
`timescale 1ns / 1ps
module nhst_back #(
    parameter int TABLE_ENTRIES = nhst_pkg::TABLE_ENTRIES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  nhst_pkg::req_t q_data,
    output logic           r_valid,
    input  logic           r_ready,
    output nhst_pkg::res_t r_data
);
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [AW:0] LAST_IDX = (AW + 1)'(TABLE_ENTRIES - 1);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_EXEC  = 6'b001000,
        ST_READ  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    nhst_pkg::req_t req_reg;
    logic [CW-1:0] count_reg;
    logic [AW:0]   idx_reg;      // read address issued
    logic [AW:0]   chk_reg;      // entry whose data is on rdata
    logic          chk_live_reg;
    logic          hit_reg;
    logic [AW-1:0] hit_idx_reg;
    logic          free_reg;
    logic [AW-1:0] free_idx_reg;
    nhst_pkg::res_t res_reg;

    logic          we;
    logic [AW-1:0] waddr;
    nhst_pkg::entry_t wdata, rdata;
    logic [AW-1:0] raddr;

    assign raddr = (state_reg == ST_SCAN) ? idx_reg[AW-1:0] : hit_idx_reg;

    nhst_ram #(.WIDTH(nhst_pkg::ENTRY_W), .DEPTH(1 << AW)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign q_ready = (state_reg == ST_IDLE);
    assign r_valid = (state_reg == ST_OUT);
    assign r_data  = res_reg;

    logic match;
    assign match = chk_live_reg && rdata.valid && rdata.v6 == req_reg.v6
                   && rdata.hi == req_reg.hi && rdata.lo == req_reg.lo;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (idx_reg == LAST_IDX) state_next = ST_IDLE;
            ST_IDLE: if (q_valid) state_next = ST_SCAN;
            ST_SCAN: if (!chk_live_reg && idx_reg == TABLE_ENTRIES[AW:0] && chk_reg != 0)
                         state_next = ST_READ;
            ST_READ: state_next = ST_EXEC;
            ST_EXEC: state_next = ST_OUT;
            ST_OUT:  if (r_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // execute: decide write and result from the entry read at hit_idx
    nhst_pkg::entry_t e;
    nhst_pkg::res_t   r;
    logic [CW-1:0]    cnt_n;
    always_comb begin
        e = rdata;
        we = 1'b0;
        waddr = hit_idx_reg;
        wdata = rdata;
        cnt_n = count_reg;
        r = '0;
        r.hi = req_reg.hi;
        r.lo = req_reg.lo;
        r.v6 = req_reg.v6;
        r.outcome = nhst_pkg::OC_NOT_FOUND;
        if (hit_reg) begin
            r.reach = e.reach; r.cv = e.cv; r.cost = e.cost; r.conn = e.conn;
        end
        case (req_reg.req)
            nhst_pkg::REQ_UPDATE, nhst_pkg::REQ_REGISTER: begin
                if (hit_reg) begin
                    if (req_reg.req == nhst_pkg::REQ_REGISTER) begin
                        we = 1'b1; wdata.regd = 1'b1;
                        r.outcome = nhst_pkg::OC_FOUND;
                    end else if (e.conn == nhst_pkg::CONN_YES
                                 && req_reg.conn != nhst_pkg::CONN_YES) begin
                        r.outcome = nhst_pkg::OC_SKIPPED;
                    end else if (e.reach == req_reg.reach && e.cv == req_reg.cv
                                 && (!req_reg.cv || e.cost == req_reg.cost)) begin
                        r.outcome = nhst_pkg::OC_UNCHANGED;
                    end else begin
                        we = 1'b1;
                        wdata.reach = req_reg.reach; wdata.cv = req_reg.cv;
                        wdata.cost = req_reg.cost; wdata.conn = req_reg.conn;
                        r.reach = req_reg.reach; r.cv = req_reg.cv;
                        r.cost = req_reg.cost; r.conn = req_reg.conn;
                        if (e.reach != req_reg.reach)
                            r.rchg = req_reg.reach ? nhst_pkg::RC_UP : nhst_pkg::RC_DOWN;
                        r.push = e.regd;
                        r.outcome = e.regd ? nhst_pkg::OC_PUSHED : nhst_pkg::OC_UPDATED;
                    end
                end else if (!free_reg) begin
                    r.outcome = nhst_pkg::OC_FULL;
                end else begin
                    we = 1'b1; waddr = free_idx_reg;
                    cnt_n = count_reg + 1'b1;
                    wdata.valid = 1'b1;
                    wdata.hi = req_reg.hi; wdata.lo = req_reg.lo; wdata.v6 = req_reg.v6;
                    if (req_reg.req == nhst_pkg::REQ_UPDATE) begin
                        wdata.reach = req_reg.reach; wdata.cv = req_reg.cv;
                        wdata.cost = req_reg.cost; wdata.conn = req_reg.conn;
                        wdata.regd = 1'b0;
                        r.outcome = nhst_pkg::OC_INSERTED;
                    end else begin
                        wdata.reach = 1'b0; wdata.cv = 1'b0; wdata.cost = '0;
                        wdata.conn = nhst_pkg::CONN_UNSET; wdata.regd = 1'b1;
                        r.outcome = nhst_pkg::OC_CREATED;
                    end
                    r.reach = wdata.reach; r.cv = wdata.cv;
                    r.cost = wdata.cost; r.conn = wdata.conn;
                end
            end
            nhst_pkg::REQ_UNREGISTER: begin
                if (hit_reg) begin
                    if (!e.reach) begin
                        we = 1'b1; wdata.valid = 1'b0;
                        cnt_n = count_reg - 1'b1;
                        r.outcome = nhst_pkg::OC_REMOVED;
                    end else begin
                        we = 1'b1; wdata.regd = 1'b0;
                        r.outcome = nhst_pkg::OC_KEPT;
                    end
                end
            end
            default: begin
                r.reach = 1'b0; r.cv = 1'b0; r.cost = '0; r.conn = '0;
            end
        endcase
        if (state_reg != ST_EXEC) begin
            we = 1'b0; cnt_n = count_reg;
        end
        // wipe one entry per cycle after reset
        if (state_reg == ST_CLEAR) begin
            we = 1'b1; waddr = idx_reg[AW-1:0]; wdata = '0;
        end
        r.count = 7'(cnt_n);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= cnt_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            case (state_reg)
                ST_CLEAR: idx_reg <= idx_reg + 1'b1;
                ST_IDLE: begin
                    if (q_valid) begin
                        req_reg <= q_data;
                        idx_reg <= '0;
                        chk_reg <= '0;
                        chk_live_reg <= 1'b0;
                        hit_reg <= 1'b0;
                        free_reg <= 1'b0;
                        hit_idx_reg <= '0;
                        free_idx_reg <= '0;
                    end
                end
                ST_SCAN: begin
                    // issue next read, compare the one returned
                    chk_live_reg <= (idx_reg != TABLE_ENTRIES[AW:0]);
                    chk_reg <= idx_reg;
                    if (idx_reg != TABLE_ENTRIES[AW:0]) idx_reg <= idx_reg + 1'b1;
                    if (chk_live_reg && !rdata.valid && !free_reg) begin
                        free_reg <= 1'b1;
                        free_idx_reg <= chk_reg[AW-1:0];
                    end
                    if (match && !hit_reg) begin
                        hit_reg <= 1'b1;
                        hit_idx_reg <= chk_reg[AW-1:0];
                    end
                end
                ST_EXEC: res_reg <= r;
                default: ;
            endcase
        end
    end
endmodule

### hdl/nexthop_status_table.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Next-hop status table.
// Input channel s_*: one request word per valid/ready handshake (update,
// register, unregister). Result channel m_*: exactly one result word per
// request, in request order.
// A two-word front queue normalizes requests (IPv4 key masking, absent
// cost zeroed) and lets the sender run ahead of the table engine.
// The engine scans the entry memory one entry per cycle through its
// registered read port, then rereads the hit entry and writes back.
// While the engine works on a request it takes no other; the next request
// word is taken only after the result has been accepted on m_*, and the
// pace is set by the key scan.
// After reset the engine clears the entry memory one entry per cycle; the
// front queue takes two words meanwhile.
// While m_ready is low the result holds on m_* and the engine waits; the
// front queue still takes up to two requests.
module nexthop_status_table #(
    parameter int TABLE_ENTRIES = nhst_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [63:0] s_addr_hi,
    input  logic [63:0] s_addr_lo,
    input  logic        s_addr_is_v6,
    input  logic        s_reachable,
    input  logic        s_cost_valid,
    input  logic [31:0] s_igp_cost,
    input  logic [1:0]  s_connected_state,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_outcome,
    output logic [63:0] m_out_addr_hi,
    output logic [63:0] m_out_addr_lo,
    output logic        m_out_is_v6,
    output logic        m_out_reachable,
    output logic        m_out_cost_valid,
    output logic [31:0] m_out_igp_cost,
    output logic [1:0]  m_out_connected,
    output logic        m_push_res,
    output logic [1:0]  m_reach_change,
    output logic [6:0]  m_entry_count
);
    logic q_valid, q_ready;
    nhst_pkg::req_t q_data;
    nhst_pkg::res_t r;

    nhst_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_addr_hi(s_addr_hi), .s_addr_lo(s_addr_lo),
        .s_addr_is_v6(s_addr_is_v6), .s_reachable(s_reachable),
        .s_cost_valid(s_cost_valid), .s_igp_cost(s_igp_cost),
        .s_connected_state(s_connected_state),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    nhst_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_data(q_data), .r_valid(m_valid), .r_ready(m_ready), .r_data(r)
    );

    assign m_outcome        = r.outcome;
    assign m_out_addr_hi    = r.hi;
    assign m_out_addr_lo    = r.lo;
    assign m_out_is_v6      = r.v6;
    assign m_out_reachable  = r.reach;
    assign m_out_cost_valid = r.cv;
    assign m_out_igp_cost   = r.cost;
    assign m_out_connected  = r.conn;
    assign m_push_res       = r.push;
    assign m_reach_change   = r.rchg;
    assign m_entry_count    = r.count;

    logic res_is_push, res_is_upd;
    assign res_is_push = (m_outcome == nhst_pkg::OC_PUSHED);
    assign res_is_upd  = res_is_push || (m_outcome == nhst_pkg::OC_UPDATED);

    `ASSERT_IMPL(a_push_oc, aclk, aresetn, m_valid |-> (m_push_res == res_is_push))
    `ASSERT_IMPL(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_outcome)))
    `ASSERT_IMPL(a_rc, aclk, aresetn, (m_valid && m_reach_change != nhst_pkg::RC_NONE) |-> res_is_upd)
endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    localparam int DEPTH = nhst_pkg::TABLE_ENTRIES_DEF;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  req;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        v6;
        logic        reach;
        logic        cv;
        logic [31:0] cost;
        logic [1:0]  conn;
    } request_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_req_type = '0;
    logic [63:0] s_addr_hi = '0;
    logic [63:0] s_addr_lo = '0;
    logic s_addr_is_v6 = 1'b0;
    logic s_reachable = 1'b0;
    logic s_cost_valid = 1'b0;
    logic [31:0] s_igp_cost = '0;
    logic [1:0] s_connected_state = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [3:0] m_outcome;
    logic [63:0] m_out_addr_hi, m_out_addr_lo;
    logic m_out_is_v6, m_out_reachable, m_out_cost_valid, m_push_res;
    logic [31:0] m_out_igp_cost;
    logic [1:0] m_out_connected, m_reach_change;
    logic [6:0] m_entry_count;

    nexthop_status_table uut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // predictor state
    logic        nh_valid [DEPTH];
    logic [63:0] nh_hi [DEPTH];
    logic [63:0] nh_lo [DEPTH];
    logic        nh_v6 [DEPTH];
    logic        nh_reach [DEPTH];
    logic        nh_cv [DEPTH];
    logic [31:0] nh_cost [DEPTH];
    logic [1:0]  nh_conn [DEPTH];
    logic        nh_regd [DEPTH];
    int          nh_count;

    request_t pending_reqs[$];
    nhst_pkg::res_t expected_status[$];
    int errors = 0;
    int results_seen = 0;
    int outcome_hits[16];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_results = 1'b0;
    bit hold_start = 1'b0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;
    // acceptance seen at the last rising edge
    logic s_ready_q = 1'b0;

    function automatic nhst_pkg::res_t lookup_apply(request_t r);
        nhst_pkg::res_t o;
        logic [1:0] conn;
        logic [63:0] hi, lo;
        logic [31:0] cost;
        int hit, slot;
        bit rchg, cchg;
        hi = r.v6 ? r.hi : 64'd0;
        lo = r.v6 ? r.lo : {32'd0, r.lo[31:0]};
        cost = r.cv ? r.cost : 32'd0;
        conn = (r.conn == nhst_pkg::CONN_RSVD) ? nhst_pkg::CONN_UNSET : r.conn;
        o = '0;
        o.hi = hi;
        o.lo = lo;
        o.v6 = r.v6;
        o.outcome = nhst_pkg::OC_NOT_FOUND;
        hit = -1;
        slot = -1;
        for (int k = 0; k < DEPTH; k++) begin
            if (hit < 0 && nh_valid[k] && nh_v6[k] == r.v6 && nh_hi[k] == hi
                && nh_lo[k] == lo)
                hit = k;
            if (slot < 0 && !nh_valid[k])
                slot = k;
        end
        if (r.req == nhst_pkg::REQ_UPDATE || r.req == nhst_pkg::REQ_REGISTER) begin
            if (hit < 0 && slot < 0) begin
                o.outcome = nhst_pkg::OC_FULL;
            end else if (hit < 0) begin
                hit = slot;
                nh_valid[hit] = 1'b1;
                nh_hi[hit] = hi;
                nh_lo[hit] = lo;
                nh_v6[hit] = r.v6;
                nh_count++;
                if (r.req == nhst_pkg::REQ_UPDATE) begin
                    nh_reach[hit] = r.reach;
                    nh_cv[hit] = r.cv;
                    nh_cost[hit] = cost;
                    nh_conn[hit] = conn;
                    nh_regd[hit] = 1'b0;
                    o.outcome = nhst_pkg::OC_INSERTED;
                end else begin
                    nh_reach[hit] = 1'b0;
                    nh_cv[hit] = 1'b0;
                    nh_cost[hit] = '0;
                    nh_conn[hit] = nhst_pkg::CONN_UNSET;
                    nh_regd[hit] = 1'b1;
                    o.outcome = nhst_pkg::OC_CREATED;
                end
            end else if (r.req == nhst_pkg::REQ_REGISTER) begin
                nh_regd[hit] = 1'b1;
                o.outcome = nhst_pkg::OC_FOUND;
            end else if (nh_conn[hit] == nhst_pkg::CONN_YES && conn != nhst_pkg::CONN_YES) begin
                o.outcome = nhst_pkg::OC_SKIPPED;
            end else begin
                rchg = nh_reach[hit] != r.reach;
                cchg = nh_cv[hit] != r.cv || (r.cv && nh_cost[hit] != cost);
                if (!rchg && !cchg) begin
                    o.outcome = nhst_pkg::OC_UNCHANGED;
                end else begin
                    nh_reach[hit] = r.reach;
                    nh_cv[hit] = r.cv;
                    nh_cost[hit] = cost;
                    nh_conn[hit] = conn;
                    if (rchg)
                        o.rchg = r.reach ? nhst_pkg::RC_UP : nhst_pkg::RC_DOWN;
                    o.push = nh_regd[hit];
                    o.outcome = nh_regd[hit] ? nhst_pkg::OC_PUSHED : nhst_pkg::OC_UPDATED;
                end
            end
        end else if (r.req == nhst_pkg::REQ_UNREGISTER && hit >= 0) begin
            o.outcome = nh_reach[hit] ? nhst_pkg::OC_KEPT : nhst_pkg::OC_REMOVED;
        end
        if (hit >= 0 && o.outcome != nhst_pkg::OC_FULL
            && o.outcome != nhst_pkg::OC_NOT_FOUND) begin
            o.reach = nh_reach[hit];
            o.cv = nh_cv[hit];
            o.cost = nh_cost[hit];
            o.conn = nh_conn[hit];
            if (o.outcome == nhst_pkg::OC_REMOVED) begin
                nh_valid[hit] = 1'b0;
                nh_count--;
            end else if (o.outcome == nhst_pkg::OC_KEPT) begin
                nh_regd[hit] = 1'b0;
            end
        end
        o.count = nh_count[6:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
    endtask

    // driver: present words at the falling edge
    always @(negedge aclk) begin
        request_t r;
        if (aresetn) begin
            if (!s_valid || s_ready_q) begin
                if (pending_reqs.size() > 0
                    && $urandom_range(99, 0) >= send_idle_pct) begin
                    r = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= r.req;
                    s_addr_hi <= r.hi;
                    s_addr_lo <= r.lo;
                    s_addr_is_v6 <= r.v6;
                    s_reachable <= r.reach;
                    s_cost_valid <= r.cv;
                    s_igp_cost <= r.cost;
                    s_connected_state <= r.conn;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= !hold_results && ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        request_t r;
        nhst_pkg::res_t e;
        s_ready_q <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            r = '{s_req_type, s_addr_hi, s_addr_lo, s_addr_is_v6, s_reachable,
                  s_cost_valid, s_igp_cost, s_connected_state};
            expected_status.push_back(lookup_apply(r));
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_status.size() == 0) begin
                report_mismatch("unexpected word", 64'(m_outcome), 64'd0);
            end else begin
                e = expected_status.pop_front();
                outcome_hits[e.outcome]++;
                if (m_outcome !== e.outcome)
                    report_mismatch("outcome", 64'(m_outcome), 64'(e.outcome));
                if (m_out_addr_hi !== e.hi) report_mismatch("addr_hi", m_out_addr_hi, e.hi);
                if (m_out_addr_lo !== e.lo) report_mismatch("addr_lo", m_out_addr_lo, e.lo);
                if (m_out_is_v6 !== e.v6)
                    report_mismatch("is_v6", 64'(m_out_is_v6), 64'(e.v6));
                if (m_out_reachable !== e.reach)
                    report_mismatch("reachable", 64'(m_out_reachable), 64'(e.reach));
                if (m_out_cost_valid !== e.cv)
                    report_mismatch("cost_valid", 64'(m_out_cost_valid), 64'(e.cv));
                if (m_out_igp_cost !== e.cost)
                    report_mismatch("igp_cost", 64'(m_out_igp_cost), 64'(e.cost));
                if (m_out_connected !== e.conn)
                    report_mismatch("connected", 64'(m_out_connected), 64'(e.conn));
                if (m_push_res !== e.push)
                    report_mismatch("push", 64'(m_push_res), 64'(e.push));
                if (m_reach_change !== e.rchg)
                    report_mismatch("reach_change", 64'(m_reach_change), 64'(e.rchg));
                if (m_entry_count !== e.count)
                    report_mismatch("entry_count", 64'(m_entry_count), 64'(e.count));
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // long receiver hold, counted here so the sender keeps offering words
    initial begin
        wait (hold_start);
        hold_results = 1'b1;
        repeat (600) @(posedge aclk);
        hold_results = 1'b0;
        hold_done = 1'b1;
    end

    // small key pool so that lookups hit often; slot 0 is an IPv4 key with junk
    logic [63:0] pool_hi [16];
    logic [63:0] pool_lo [16];
    logic        pool_v6 [16];

    function automatic request_t make_req(logic [1:0] req, int key, bit reach, bit cv,
                                          logic [31:0] cost, logic [1:0] conn);
        request_t r;
        r.req = req;
        r.v6 = pool_v6[key];
        // IPv4 keys carry random upper bits that must be ignored
        r.hi = pool_v6[key] ? pool_hi[key] : {$urandom, $urandom};
        r.lo = pool_v6[key] ? pool_lo[key] : {$urandom, pool_lo[key][31:0]};
        r.reach = reach;
        r.cv = cv;
        r.cost = cost;
        r.conn = conn;
        return r;
    endfunction

    function automatic request_t random_req(int keys);
        logic [1:0] req;
        int pick;
        pick = int'($urandom_range(99, 0));
        req = pick < 55 ? nhst_pkg::REQ_UPDATE : pick < 75 ? nhst_pkg::REQ_REGISTER :
              pick < 97 ? nhst_pkg::REQ_UNREGISTER : nhst_pkg::REQ_RSVD;
        return make_req(req, int'($urandom_range(keys - 1, 0)), 1'($urandom_range(1, 0)),
                        1'($urandom_range(1, 0)),
                        $urandom_range(3, 0) == 0 ? $urandom : $urandom_range(3, 0),
                        2'($urandom_range(3, 0)));
    endfunction

    task automatic drain(int extra);
        while (pending_reqs.size() > 0 || s_valid || expected_status.size() > 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    initial begin
        request_t r;
        for (int k = 0; k < DEPTH; k++) nh_valid[k] = 1'b0;
        nh_count = 0;
        for (int k = 0; k < 16; k++) begin
            pool_v6[k] = k[0];
            pool_hi[k] = {$urandom, $urandom};
            pool_lo[k] = {$urandom, $urandom};
        end
        pool_hi[1] = '1;
        pool_lo[1] = '1;
        pool_hi[3] = '0;
        pool_lo[3] = '0;
        pool_lo[2] = 64'h0000_0000_ffff_ffff;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: insert, unchanged, connected rule, register, push, remove
        pending_reqs.push_back(make_req(nhst_pkg::REQ_UPDATE, 0, 1'b1, 1'b1,
                                        32'hffff_ffff, nhst_pkg::CONN_YES));
        pending_reqs.push_back(make_req(nhst_pkg::REQ_UPDATE, 0, 1'b1, 1'b1,
                                        32'hffff_ffff, nhst_pkg::CONN_YES));
        pending_reqs.push_back(make_req(nhst_pkg::REQ_UPDATE, 0, 1'b0, 1'b0,
                                        32'h1234, nhst_pkg::CONN_NO));
        pending_reqs.push_back(make_req(nhst_pkg::REQ_REGISTER, 0, 1'b0, 1'b0,
                                        32'd0, nhst_pkg::CONN_UNSET));
        pending_reqs.push_back(make_req(nhst_pkg::REQ_UPDATE, 0, 1'b0, 1'b1,
                                        32'd0, nhst_pkg::CONN_YES));
        pending_reqs.push_back(make_req(nhst_pkg::REQ_UNREGISTER, 0, 1'b0, 1'b0,
                                        32'd0, nhst_pkg::CONN_UNSET));
        pending_reqs.push_back(make_req(nhst_pkg::REQ_UPDATE, 0, 1'b1, 1'b0,
                                        32'd7, nhst_pkg::CONN_RSVD));
        pending_reqs.push_back(make_req(nhst_pkg::REQ_UNREGISTER, 0, 1'b0, 1'b0,
                                        32'd0, nhst_pkg::CONN_UNSET));
        pending_reqs.push_back(make_req(nhst_pkg::REQ_UNREGISTER, 0, 1'b0, 1'b0,
                                        32'd0, nhst_pkg::CONN_UNSET));
        pending_reqs.push_back(make_req(nhst_pkg::REQ_REGISTER, 1, 1'b1, 1'b1,
                                        32'd5, nhst_pkg::CONN_YES));
        pending_reqs.push_back(make_req(nhst_pkg::REQ_UPDATE, 1, 1'b1, 1'b0,
                                        32'hdead, nhst_pkg::CONN_UNSET));
        pending_reqs.push_back(make_req(nhst_pkg::REQ_UPDATE, 1, 1'b1, 1'b1,
                                        32'd0, nhst_pkg::CONN_NO));
        pending_reqs.push_back(make_req(nhst_pkg::REQ_UNREGISTER, 1, 1'b0, 1'b0,
                                        32'd0, nhst_pkg::CONN_UNSET));
        pending_reqs.push_back(make_req(nhst_pkg::REQ_UPDATE, 2, 1'b0, 1'b1,
                                        32'hffff_ffff, nhst_pkg::CONN_UNSET));
        pending_reqs.push_back(make_req(nhst_pkg::REQ_UPDATE, 3, 1'b1, 1'b1,
                                        32'd0, nhst_pkg::CONN_UNSET));
        pending_reqs.push_back(make_req(nhst_pkg::REQ_RSVD, 3, 1'b1, 1'b1,
                                        32'd1, nhst_pkg::CONN_RSVD));
        drain(0);

        // fill the table with fresh keys to reach the full case
        for (int n = 0; n < DEPTH + 4; n++) begin
            r = make_req(nhst_pkg::REQ_REGISTER, 1, 1'b0, 1'b0, 32'd0, nhst_pkg::CONN_UNSET);
            r.hi = {$urandom, $urandom};
            r.lo = {$urandom, $urandom};
            pending_reqs.push_back(r);
        end
        pending_reqs.push_back(make_req(nhst_pkg::REQ_UPDATE, 5, 1'b1, 1'b1,
                                        32'd9, nhst_pkg::CONN_YES));
        drain(0);

        // hold off the receiver so the front queue fills and s_ready drops
        for (int n = 0; n < 8; n++) pending_reqs.push_back(random_req(8));
        hold_start = 1'b1;
        wait (hold_done);
        drain(0);

        // empty the table: unregister everything after forcing unreachable
        for (int k = 0; k < DEPTH; k++) begin
            if (nh_valid[k]) begin
                r = make_req(nhst_pkg::REQ_UPDATE, 1, 1'b0, 1'b0, 32'd0, nhst_pkg::CONN_YES);
                r.v6 = nh_v6[k];
                r.hi = nh_hi[k];
                r.lo = nh_lo[k];
                pending_reqs.push_back(r);
                r.req = nhst_pkg::REQ_UNREGISTER;
                pending_reqs.push_back(r);
            end
        end
        drain(0);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = phase == 1 || phase == 3 ? (phase == 3 ? 34 : 88) : 0;
            recv_stall_pct = phase == 2 || phase == 3 ? (phase == 3 ? 34 : 88) : 0;
            for (int n = 0; n < 480; n++) pending_reqs.push_back(random_req(16));
            drain(0);
        end
        drain(150);

        $display("covered %0d results; inserted %0d, pushed %0d, skipped %0d, full %0d,",
                 results_seen, outcome_hits[nhst_pkg::OC_INSERTED],
                 outcome_hits[nhst_pkg::OC_PUSHED], outcome_hits[nhst_pkg::OC_SKIPPED],
                 outcome_hits[nhst_pkg::OC_FULL]);
        $display("removed %0d, kept %0d; mismatches %0d",
                 outcome_hits[nhst_pkg::OC_REMOVED], outcome_hits[nhst_pkg::OC_KEPT], errors);
        if (errors == 0 && expected_status.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/nhst_pkg.sv
hdl/nhst_ram.sv
hdl/nhst_front.sv
hdl/nhst_back.sv
hdl/nexthop_status_table.sv
bench/tb_top.sv
